// ===== rtl/core/pbmp_pkg.sv =====
// Shared types, sizes and constants of the periodic binned mean predictor.
package pbmp_pkg;

  // Built sizes
  localparam int MAX_BINS   = 64;
  localparam int COUNT_BITS = 24;

  // Field widths
  localparam int KIND_BITS    = 2;
  localparam int TIME_BITS    = 32;
  localparam int FX_BITS      = 17;
  localparam int BIN_OUT_BITS = 6;
  localparam int PERIOD_BITS  = 24;
  localparam int NB_BITS      = 7;
  localparam int MODELS_BITS  = 8;

  // Configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 24;
  localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD     = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_NUM_BINS   = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_NUM_MODELS = CFG_IDX_BITS'(2);

  // Derived sizes
  localparam int BIN_BITS  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int SUM_BITS  = COUNT_BITS + FX_BITS;
  localparam int DIV_BITS  = (COUNT_BITS > PERIOD_BITS) ? COUNT_BITS : PERIOD_BITS;
  localparam int PROD_BITS = DIV_BITS + NB_BITS;
  localparam int DQ_MIN    = (SUM_BITS > TIME_BITS) ? SUM_BITS : TIME_BITS;
  localparam int DQ_BITS   = (DQ_MIN > PROD_BITS) ? DQ_MIN : PROD_BITS;
  localparam int CNT_BITS  = $clog2(DQ_BITS + 1);

  // Transaction kinds
  localparam logic [KIND_BITS-1:0] KIND_ADD     = KIND_BITS'(0);
  localparam logic [KIND_BITS-1:0] KIND_LIVE    = KIND_BITS'(1);
  localparam logic [KIND_BITS-1:0] KIND_REFRESH = KIND_BITS'(2);
  localparam logic [KIND_BITS-1:0] KIND_SNAP    = KIND_BITS'(3);

  // Fixed-point constants, scale 65536
  localparam logic [FX_BITS-1:0] ONE_FX   = FX_BITS'(65536);
  localparam logic [FX_BITS-1:0] HALF_FX  = FX_BITS'(32768);
  localparam logic [FX_BITS-1:0] CLAMP_LO = FX_BITS'(66);
  localparam logic [FX_BITS-1:0] CLAMP_HI = FX_BITS'(65470);

  // Register reset values
  localparam logic [PERIOD_BITS-1:0] PERIOD_RESET     = PERIOD_BITS'(86400);
  localparam logic [NB_BITS-1:0]     NUM_BINS_RESET   = NB_BITS'(64);
  localparam logic [MODELS_BITS-1:0] NUM_MODELS_RESET = MODELS_BITS'(2);

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic [TIME_BITS-1:0] time_req;
    logic [FX_BITS-1:0]   state;
  } req_t;

  typedef struct packed {
    logic [FX_BITS-1:0]      estimate;
    logic [BIN_OUT_BITS-1:0] bin;
  } rsp_t;

  // Limit an estimate to [0.001, 0.999]
  function automatic logic [FX_BITS-1:0] fx_clamp(input logic [FX_BITS-1:0] v);
    logic [FX_BITS-1:0] r;
    if (v > CLAMP_HI) r = CLAMP_HI;
    else if (v < CLAMP_LO) r = CLAMP_LO;
    else r = v;
    return r;
  endfunction

endpackage

// ===== rtl/core/periodic_binned_mean_predictor.sv =====
// Periodic binned mean predictor: bin mapping, bin statistics and snapshot table.
// One transaction at a time; the next is taken when the result is out. A shared
// restoring divider, one bit per cycle, takes 32 steps for time mod period, 31 for
// the bin, 41 per mean (17 for the empty-bin default).
// Reset (synchronous, active high) restores the registers and marks all bin and
// snapshot entries invalid, so they read as empty and one half at once.
module periodic_binned_mean_predictor
  import pbmp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  req_t                     req,
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output rsp_t                     rsp,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_MOD, S_MUL, S_BIN, S_READ, S_DATA, S_MEAN, S_LIVE_END,
    S_OUT, S_REF_READ, S_REF_DATA, S_REF_DIV, S_REF_WRITE
  } state_t;

  state_t state;

  // Configuration registers
  logic [PERIOD_BITS-1:0] period;
  logic [NB_BITS-1:0]     num_bins;
  logic [MODELS_BITS-1:0] num_models;

  always_ff @(posedge clk) begin
    if (rst) begin
      period     <= PERIOD_RESET;
      num_bins   <= NUM_BINS_RESET;
      num_models <= NUM_MODELS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PERIOD:     period     <= cfg_data[PERIOD_BITS-1:0];
        REG_NUM_BINS:   num_bins   <= cfg_data[NB_BITS-1:0];
        REG_NUM_MODELS: num_models <= cfg_data[MODELS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Register values with the zero and range special cases applied
  logic [PERIOD_BITS-1:0] p_eff;
  logic [NB_BITS-1:0]     nb_eff;
  logic [MODELS_BITS-1:0] m_eff;

  always_comb begin
    p_eff = (period == '0) ? PERIOD_BITS'(1) : period;
    m_eff = (num_models == '0) ? MODELS_BITS'(1) : num_models;
    if (num_bins == '0) nb_eff = NB_BITS'(1);
    else if (32'(num_bins) > MAX_BINS) nb_eff = NB_BITS'(MAX_BINS);
    else nb_eff = num_bins;
  end

  // Working registers
  logic [DQ_BITS-1:0]      dq;
  logic [DIV_BITS-1:0]     rem;
  logic [DIV_BITS-1:0]     divisor;
  logic [CNT_BITS-1:0]     cnt;
  logic [BIN_BITS-1:0]     addr;
  logic [KIND_BITS-1:0]    kind_q;
  logic [FX_BITS-1:0]      st_q;
  logic [FX_BITS-1:0]      res_est;
  logic [BIN_OUT_BITS-1:0] res_bin;
  logic                    ref_empty;

  // Memories and their registered read data
  logic [SUM_BITS-1:0]   bin_sum       [MAX_BINS];
  logic [COUNT_BITS-1:0] bin_count     [MAX_BINS];
  logic [FX_BITS-1:0]    snapshot_mean [MAX_BINS];
  logic [MAX_BINS-1:0]   bin_vld;
  logic [MAX_BINS-1:0]   snap_vld;
  logic [SUM_BITS-1:0]   sum_rd;
  logic [COUNT_BITS-1:0] cnt_rd;
  logic [FX_BITS-1:0]    snap_rd;
  logic                  bin_vld_rd;
  logic                  snap_vld_rd;

  // Entries never written read as empty bin / one half
  logic [SUM_BITS-1:0]   sum_eff;
  logic [COUNT_BITS-1:0] cnt_eff;
  logic [FX_BITS-1:0]    snap_eff;
  logic                  cnt_full;
  logic                  sum_we;
  logic                  snap_we;
  logic [FX_BITS-1:0]    snap_wdata;
  logic [SUM_BITS-1:0]   sum_wdata;

  assign sum_eff    = bin_vld_rd ? sum_rd : '0;
  assign cnt_eff    = bin_vld_rd ? cnt_rd : '0;
  assign snap_eff   = snap_vld_rd ? snap_rd : HALF_FX;
  assign cnt_full   = (cnt_eff == {COUNT_BITS{1'b1}});
  assign sum_we     = (state == S_DATA) && (kind_q == KIND_ADD) && !cnt_full;
  assign snap_we    = (state == S_REF_WRITE);
  assign snap_wdata = ref_empty ? HALF_FX : dq[FX_BITS-1:0];
  assign sum_wdata  = sum_eff + SUM_BITS'(st_q);

  always_ff @(posedge clk) begin
    if (sum_we) begin
      bin_sum[addr]   <= sum_wdata;
      bin_count[addr] <= cnt_eff + COUNT_BITS'(1);
    end
    if (snap_we) snapshot_mean[addr] <= snap_wdata;
    sum_rd  <= bin_sum[addr];
    cnt_rd  <= bin_count[addr];
    snap_rd <= snapshot_mean[addr];
  end

  // Valid bits stand in for clearing the memories at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_vld     <= '0;
      snap_vld    <= '0;
      bin_vld_rd  <= 1'b0;
      snap_vld_rd <= 1'b0;
    end else begin
      if (sum_we) bin_vld[addr] <= 1'b1;
      if (snap_we) snap_vld[addr] <= 1'b1;
      bin_vld_rd  <= bin_vld[addr];
      snap_vld_rd <= snap_vld[addr];
    end
  end

  // One restoring divide step: shift in the next dividend bit, try subtract
  logic [DIV_BITS:0]   rem_shift;
  logic [DIV_BITS:0]   diff;
  logic                q_bit;
  logic [DIV_BITS-1:0] rem_next;
  logic [DQ_BITS-1:0]  dq_next;
  logic                div_active;
  logic                div_last;
  logic [PROD_BITS-1:0] prod;

  assign rem_shift  = {rem, dq[DQ_BITS-1]};
  assign diff       = rem_shift - {1'b0, divisor};
  assign q_bit      = !diff[DIV_BITS];
  assign rem_next   = q_bit ? diff[DIV_BITS-1:0] : rem_shift[DIV_BITS-1:0];
  assign dq_next    = {dq[DQ_BITS-2:0], q_bit};
  assign div_active = (state inside {S_MOD, S_BIN, S_MEAN, S_REF_DIV});
  assign div_last   = (cnt == CNT_BITS'(1));
  assign prod       = PROD_BITS'(rem) * PROD_BITS'(nb_eff);

  assign req_stall = (state != S_IDLE);

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      // S_OUT drives rsp_valid itself
      if (rsp_valid && !rsp_stall && state != S_OUT) rsp_valid <= 1'b0;

      if (div_active) begin
        dq  <= dq_next;
        rem <= rem_next;
        cnt <= cnt - CNT_BITS'(1);
      end

      case (state)
        S_IDLE: begin
          if (req_valid) begin
            kind_q <= req.kind;
            st_q   <= (req.state > ONE_FX) ? ONE_FX : req.state;
            if (req.kind == KIND_REFRESH) begin
              addr    <= '0;
              res_est <= '0;
              res_bin <= '0;
              state   <= S_REF_READ;
            end else begin
              dq      <= DQ_BITS'(req.time_req) << (DQ_BITS - TIME_BITS);
              rem     <= '0;
              divisor <= DIV_BITS'(p_eff);
              cnt     <= CNT_BITS'(TIME_BITS);
              state   <= S_MOD;
            end
          end
        end
        S_MOD: begin
          if (div_last) state <= S_MUL;
        end
        // rem now holds time mod period; scale by the bin count
        S_MUL: begin
          dq    <= DQ_BITS'(prod) << (DQ_BITS - PROD_BITS);
          rem   <= '0;
          cnt   <= CNT_BITS'(PROD_BITS);
          state <= S_BIN;
        end
        S_BIN: begin
          if (div_last) begin
            addr    <= dq_next[BIN_BITS-1:0];
            res_bin <= BIN_OUT_BITS'(dq_next[BIN_BITS-1:0]);
            state   <= S_READ;
          end
        end
        S_READ: state <= S_DATA;
        S_DATA: begin
          case (kind_q)
            KIND_LIVE: begin
              rem <= '0;
              if (cnt_eff != '0) begin
                dq      <= DQ_BITS'(sum_eff) << (DQ_BITS - SUM_BITS);
                divisor <= DIV_BITS'(cnt_eff);
                cnt     <= CNT_BITS'(SUM_BITS);
              end else begin
                dq      <= DQ_BITS'(ONE_FX) << (DQ_BITS - FX_BITS);
                divisor <= DIV_BITS'(m_eff);
                cnt     <= CNT_BITS'(FX_BITS);
              end
              state <= S_MEAN;
            end
            KIND_SNAP: begin
              res_est <= fx_clamp(snap_eff);
              state   <= S_OUT;
            end
            default: begin
              res_est <= '0;
              state   <= S_OUT;
            end
          endcase
        end
        S_MEAN: begin
          if (div_last) state <= S_LIVE_END;
        end
        S_LIVE_END: begin
          res_est <= fx_clamp(dq[FX_BITS-1:0]);
          state   <= S_OUT;
        end
        S_OUT: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid    <= 1'b1;
            rsp.estimate <= res_est;
            rsp.bin      <= res_bin;
            state        <= S_IDLE;
          end
        end
        // Refresh walks every bin in order
        S_REF_READ: state <= S_REF_DATA;
        S_REF_DATA: begin
          if (cnt_eff != '0) begin
            dq        <= DQ_BITS'(sum_eff) << (DQ_BITS - SUM_BITS);
            rem       <= '0;
            divisor   <= DIV_BITS'(cnt_eff);
            cnt       <= CNT_BITS'(SUM_BITS);
            ref_empty <= 1'b0;
            state     <= S_REF_DIV;
          end else begin
            ref_empty <= 1'b1;
            state     <= S_REF_WRITE;
          end
        end
        S_REF_DIV: begin
          if (div_last) state <= S_REF_WRITE;
        end
        S_REF_WRITE: begin
          if (addr == BIN_BITS'(MAX_BINS - 1)) begin
            state <= S_OUT;
          end else begin
            addr  <= addr + BIN_BITS'(1);
            state <= S_REF_READ;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Divider remainder stays below the divisor while a division runs
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    div_active |-> (rem < divisor))
    else $error("divider remainder not below divisor");

  // Step counter never runs out during a division
  a_cnt_live: assert property (@(posedge clk) disable iff (rst)
    div_active |-> (cnt != '0))
    else $error("divider step count exhausted while active");

  // Memories change only while a transaction is in work
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    (sum_we || snap_we) |-> req_stall)
    else $error("memory write while idle");

  // Snapshot table is written only by a refresh
  a_snap_refresh: assert property (@(posedge clk) disable iff (rst)
    snap_we |-> (kind_q == KIND_REFRESH))
    else $error("snapshot write outside refresh");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the periodic binned mean predictor.
module tb_top;
  import pbmp_pkg::*;

  localparam int IDLE_PCT    = 22;
  localparam int WATCHDOG    = 20000;
  localparam int SETTLE      = 150;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 230;

  // Index with no register behind it; writes to it must change nothing
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = CFG_IDX_BITS'(3);

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     req_valid = 1'b0;
  logic                     req_stall;
  req_t                     req       = '0;
  logic                     rsp_valid;
  logic                     rsp_stall = 1'b0;
  rsp_t                     rsp;
  logic                     cfg_write = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

  periodic_binned_mean_predictor dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow registers and bin stores of the predictor
  logic [PERIOD_BITS-1:0] mdl_period;
  logic [NB_BITS-1:0]     mdl_bins;
  logic [MODELS_BITS-1:0] mdl_models;
  logic [SUM_BITS-1:0]    hist_sum   [MAX_BINS];
  logic [COUNT_BITS-1:0]  hist_count [MAX_BINS];
  logic [FX_BITS-1:0]     snap_mean  [MAX_BINS];

  req_t        queued_requests[$];
  rsp_t        pending_estimates[$];
  bit          steady = 1'b0;
  int          errors = 0;
  int          results_checked = 0;
  int          configs_used = 0;
  int          kind_seen[4] = '{0, 0, 0, 0};
  int unsigned quiet_cycles = 0;

  // Fold a timestamp into the cycle and scale it to a bin
  function automatic logic [BIN_OUT_BITS-1:0] fold_time(logic [TIME_BITS-1:0] t);
    logic [63:0] p;
    logic [63:0] nb;
    logic [63:0] idx;
    p = (mdl_period == 0) ? 64'd1 : 64'(mdl_period);
    if (mdl_bins == 0) nb = 64'd1;
    else if (mdl_bins > MAX_BINS) nb = 64'(MAX_BINS);
    else nb = 64'(mdl_bins);
    idx = ((64'(t) % p) * nb / p) % nb;
    return idx[BIN_OUT_BITS-1:0];
  endfunction

  function automatic logic [FX_BITS-1:0] limit_estimate(logic [63:0] v);
    if (v > 64'(CLAMP_HI)) return CLAMP_HI;
    if (v < 64'(CLAMP_LO)) return CLAMP_LO;
    return v[FX_BITS-1:0];
  endfunction

  function automatic logic [63:0] bin_average(int b);
    return 64'(hist_sum[b]) / 64'(hist_count[b]);
  endfunction

  // Update the stores for one accepted transaction and queue its result
  task automatic predict_estimate(input req_t r);
    rsp_t               e;
    logic [FX_BITS-1:0] st;
    logic [63:0]        avg;
    int                 i;
    e = '0;
    case (r.kind)
      KIND_ADD: begin
        e.bin = fold_time(r.time_req);
        st = (r.state > ONE_FX) ? ONE_FX : r.state;
        // a saturated counter freezes the bin
        if (hist_count[e.bin] != '1) begin
          hist_sum[e.bin]   += SUM_BITS'(st);
          hist_count[e.bin] += COUNT_BITS'(1);
        end
      end
      KIND_LIVE: begin
        e.bin = fold_time(r.time_req);
        if (hist_count[e.bin] != 0) begin
          e.estimate = limit_estimate(bin_average(e.bin));
        end else begin
          avg = 64'(ONE_FX) / ((mdl_models == 0) ? 64'd1 : 64'(mdl_models));
          e.estimate = limit_estimate(avg);
        end
      end
      KIND_REFRESH: begin
        for (i = 0; i < MAX_BINS; i++) begin
          avg = (hist_count[i] != 0) ? bin_average(i) : 64'(HALF_FX);
          snap_mean[i] = avg[FX_BITS-1:0];
        end
      end
      default: begin
        e.bin = fold_time(r.time_req);
        e.estimate = limit_estimate(64'(snap_mean[e.bin]));
      end
    endcase
    kind_seen[r.kind]++;
    pending_estimates.push_back(e);
  endtask

  // Register shadow follows the write port
  always @(posedge clk) begin
    if (rst) begin
      mdl_period <= PERIOD_RESET;
      mdl_bins   <= NUM_BINS_RESET;
      mdl_models <= NUM_MODELS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PERIOD:     mdl_period <= cfg_data[PERIOD_BITS-1:0];
        REG_NUM_BINS:   mdl_bins   <= cfg_data[NB_BITS-1:0];
        REG_NUM_MODELS: mdl_models <= cfg_data[MODELS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Request driver: predicts on acceptance, then loads the next queued item
  always @(posedge clk) begin : drive_req
    int i;
    bit free;
    bit load;
    if (rst) begin
      req_valid <= 1'b0;
      for (i = 0; i < MAX_BINS; i++) begin
        hist_sum[i]   = '0;
        hist_count[i] = '0;
        snap_mean[i]  = HALF_FX;
      end
    end else begin
      if (req_valid && !req_stall) predict_estimate(req);
      free = !req_valid || !req_stall;
      load = free && queued_requests.size() != 0 &&
             (steady || $urandom_range(99) >= IDLE_PCT);
      if (load) begin
        req       <= queued_requests.pop_front();
        req_valid <= 1'b1;
      end else if (free) begin
        req_valid <= 1'b0;
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk) begin : check_rsp
    rsp_t e;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (pending_estimates.size() == 0) begin
          $error("unexpected result: estimate %0d bin %0d", rsp.estimate, rsp.bin);
          errors++;
        end else begin
          e = pending_estimates.pop_front();
          results_checked++;
          if (rsp.estimate !== e.estimate) begin
            $error("estimate: expected %0d, actual %0d", e.estimate, rsp.estimate);
            errors++;
          end
          if (rsp.bin !== e.bin) begin
            $error("bin: expected %0d, actual %0d", e.bin, rsp.bin);
            errors++;
          end
        end
      end
      rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_item(logic [KIND_BITS-1:0] k, logic [TIME_BITS-1:0] t,
                           logic [FX_BITS-1:0] s);
    req_t r;
    r.kind     = k;
    r.time_req = t;
    r.state    = s;
    queued_requests.push_back(r);
  endtask

  task automatic write_register(logic [CFG_IDX_BITS-1:0] idx,
                                logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Block idle: nothing queued, nothing in flight, then let it settle.
  // Sampled on the falling edge so the driver's updates have landed.
  task automatic wait_quiet();
    @(negedge clk);
    while (queued_requests.size() != 0 || req_valid || pending_estimates.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Mostly times within the first 201 periods so bins fill; some full-range and wrap-edge times
  function automatic req_t random_request(logic [PERIOD_BITS-1:0] per);
    req_t        r;
    int unsigned p;
    int          pick;
    p = (per == '0) ? 1 : 32'(per);
    pick = $urandom_range(99);
    if (pick < 45) r.kind = KIND_ADD;
    else if (pick < 75) r.kind = KIND_LIVE;
    else if (pick < 78) r.kind = KIND_REFRESH;
    else r.kind = KIND_SNAP;
    pick = $urandom_range(99);
    if (pick < 30) r.time_req = $urandom();
    else if (pick < 70) r.time_req = $urandom_range(p - 1, 0);
    else if (pick < 85) r.time_req = p * $urandom_range(200, 0) + $urandom_range(p - 1, 0);
    else r.time_req = 32'hFFFF_FFFF - $urandom_range(1000, 0);
    pick = $urandom_range(99);
    if (pick < 70) r.state = FX_BITS'($urandom_range(65536, 0));
    else if (pick < 80) r.state = $urandom_range(1) ? ONE_FX : '0;
    else if (pick < 90) r.state = FX_BITS'($urandom_range(131071, 65537));
    else r.state = FX_BITS'($urandom_range(200, 0));
    return r;
  endfunction

  initial begin
    int                       ph;
    int                       n;
    logic [CFG_DATA_BITS-1:0] per;
    logic [CFG_DATA_BITS-1:0] nb;
    logic [CFG_DATA_BITS-1:0] nm;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset registers, empty bins, clamp at both ends, saturated state
    push_item(KIND_LIVE, 32'd0, '0);
    push_item(KIND_SNAP, 32'd0, '1);
    push_item(KIND_ADD, 32'd0, '0);
    push_item(KIND_LIVE, 32'd0, '0);
    push_item(KIND_ADD, 32'd86399, ONE_FX);
    push_item(KIND_ADD, 32'd86399, '1);
    push_item(KIND_LIVE, 32'd86399, '0);
    push_item(KIND_ADD, 32'hFFFF_FFFF, FX_BITS'(12345));
    push_item(KIND_ADD, 32'd1350, FX_BITS'(100));
    push_item(KIND_LIVE, 32'd1350, '0);
    push_item(KIND_REFRESH, 32'hFFFF_FFFF, '1);
    push_item(KIND_SNAP, 32'd0, '0);
    push_item(KIND_SNAP, 32'd86399, '0);
    push_item(KIND_SNAP, 32'd5000, '0);
    push_item(KIND_LIVE, 32'hFFFF_FFFF, '0);
    wait_quiet();
    configs_used++;

    // Bin count above the maximum, empty-bin default with the widest divisor
    write_register(REG_PERIOD, 24'd64);
    write_register(REG_NUM_BINS, 24'd127);
    write_register(REG_NUM_MODELS, 24'd255);
    push_item(KIND_LIVE, 32'd62, '0);
    push_item(KIND_SNAP, 32'd62, '0);
    wait_quiet();
    // Zero divisor gives one before the clamp
    write_register(REG_NUM_MODELS, 24'd0);
    push_item(KIND_LIVE, 32'd61, '0);
    wait_quiet();
    // Zero period and zero bin count map everything to bin zero
    write_register(REG_PERIOD, 24'd0);
    write_register(REG_NUM_BINS, 24'd0);
    push_item(KIND_ADD, 32'd777, FX_BITS'(40000));
    push_item(KIND_LIVE, 32'd12345, '0);
    push_item(KIND_SNAP, 32'd5, '0);
    wait_quiet();
    configs_used += 3;

    // Random phases, one register setting each
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          per = 24'd1; nb = 24'd1; nm = 24'd1;
        end
        1: begin
          per = 24'hFF_FFFF; nb = 24'd64; nm = 24'd255;
        end
        2: begin
          per = CFG_DATA_BITS'($urandom_range(5000, 1));
          nb  = CFG_DATA_BITS'($urandom_range(64, 1));
          nm  = CFG_DATA_BITS'($urandom_range(255, 1));
        end
        3: begin
          per = 24'd86400; nb = 24'd64; nm = 24'd2;
        end
        4: begin
          per = '0; nb = '0; nm = '0;
        end
        5: begin
          per = CFG_DATA_BITS'($urandom());
          nb  = 24'd127;
          nm  = CFG_DATA_BITS'($urandom_range(255, 0));
        end
        6: begin
          // upper data bits beyond the register width must be dropped
          per = CFG_DATA_BITS'($urandom_range(1000, 64));
          nb  = CFG_DATA_BITS'($urandom());
          nm  = CFG_DATA_BITS'($urandom());
        end
        default: begin
          per = CFG_DATA_BITS'($urandom_range(200, 1));
          nb  = CFG_DATA_BITS'($urandom_range(64, 1));
          nm  = CFG_DATA_BITS'($urandom_range(255, 1));
        end
      endcase
      write_register(REG_PERIOD, per);
      write_register(REG_NUM_BINS, nb);
      write_register(REG_NUM_MODELS, nm);
      if (ph == 2) write_register(REG_UNUSED, CFG_DATA_BITS'($urandom()));
      steady <= (ph == 3);
      for (n = 0; n < PHASE_ITEMS; n++)
        queued_requests.push_back(random_request(per[PERIOD_BITS-1:0]));
      wait_quiet();
      configs_used++;
    end

    $display("Covered %0d register settings: %0d adds, %0d live, %0d refresh, %0d snapshot",
             configs_used, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
    $display("%0d results checked, %0d mismatches", results_checked, errors);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
